FILE: design/julia_escape_time_pixel_defines.svh
// Assertion macros shared by the Julia escape-time pixel design files.
`ifndef JULIA_ESCAPE_TIME_PIXEL_DEFINES_SVH
`define JULIA_ESCAPE_TIME_PIXEL_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, sampled on aclk, off while aresetn is low
`define JETS_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, sampled on aclk, off while aresetn is low
`define JETS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define JETS_ASSERT_IMPLY(lbl, ante, cons, msg)
`define JETS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

FILE: design/jets_pkg.sv
// Shared constants, types and helpers of the Julia escape-time pixel pipeline.
package jets_pkg;

    // Frame and iteration limits
    localparam int COLUMNS        = 1024;
    localparam int ROWS           = 1024;
    localparam int MAX_ITERATIONS = 32;
    localparam int FRAC_BITS      = 28;

    // Field widths
    localparam int COORD_W   = 10;
    localparam int COUNT_W   = 6;
    localparam int COLOR_W   = 8;
    localparam int FIX_W     = 32;
    localparam int MUL_W     = 2 * FIX_W;
    localparam int SUM_W     = 48;
    localparam int CMUL_W    = COORD_W + 1 + FIX_W;

    // Stream and register port widths
    localparam int S_TDATA_W  = 24;
    localparam int M_FIELDS_W = 2 * COORD_W + COUNT_W + 3 * COLOR_W;
    localparam int M_TDATA_W  = 56;
    localparam int M_PAD_W    = M_TDATA_W - M_FIELDS_W;
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;

    typedef logic signed [FIX_W-1:0]  fix_t;
    typedef logic signed [MUL_W-1:0]  mul_t;
    typedef logic signed [SUM_W-1:0]  sum_t;
    typedef logic [COUNT_W-1:0]       count_t;
    typedef logic [COORD_W-1:0]       coord_t;

    localparam fix_t   FIX_MAX   = {1'b0, {(FIX_W-1){1'b1}}};
    localparam fix_t   FIX_MIN   = {1'b1, {(FIX_W-1){1'b0}}};
    localparam sum_t   FOUR_FIX  = sum_t'(4) <<< FRAC_BITS;
    localparam count_t MAX_COUNT = count_t'(MAX_ITERATIONS);

    // Register map, word index
    typedef enum logic [2:0] {
        REG_ORIGIN_RE = 3'd0,
        REG_ORIGIN_IM = 3'd1,
        REG_STEP_RE   = 3'd2,
        REG_STEP_IM   = 3'd3,
        REG_CONST_RE  = 3'd4,
        REG_CONST_IM  = 3'd5,
        REG_MAX_ITER  = 3'd6
    } reg_idx_t;

    // Register reset values
    localparam fix_t   RST_ORIGIN_RE = -32'sd402653184;
    localparam fix_t   RST_ORIGIN_IM = -32'sd402653184;
    localparam fix_t   RST_STEP_RE   = 32'sd1342177;
    localparam fix_t   RST_STEP_IM   = 32'sd1342177;
    localparam fix_t   RST_CONST_RE  = -32'sd214748365;
    localparam fix_t   RST_CONST_IM  = 32'sd41875931;
    localparam count_t RST_MAX_ITER  = 6'd20;

    // Point handed from cell to cell
    typedef struct packed {
        logic   vld;
        logic   run;
        count_t count;
        fix_t   zx;
        fix_t   zy;
        coord_t col;
        coord_t row;
    } pix_t;

    // Point with its three products, between the two halves of a cell
    typedef struct packed {
        logic   vld;
        logic   run;
        count_t count;
        fix_t   zx;
        fix_t   zy;
        coord_t col;
        coord_t row;
        mul_t   pxx;
        mul_t   pyy;
        mul_t   pxy;
    } sq_t;

    // Clamp a wide sum to the signed fixed-point range
    function automatic fix_t sat_fix(input sum_t v);
        if (v > sum_t'(FIX_MAX)) begin
            return FIX_MAX;
        end else if (v < sum_t'(FIX_MIN)) begin
            return FIX_MIN;
        end else begin
            return v[FIX_W-1:0];
        end
    endfunction

endpackage

FILE: design/julia_escape_time_pixel.sv
// Top level: register port, entry stages, chain of iteration cells, output queue.
// Pipeline: 67 register stages from input transfer to m_tvalid (2 entry,
// 2 per cell for 32 cells, 1 queue write; the first loads at the transfer edge).
// Throughput: one pixel per cycle while the queue has room, set by the 32 two-stage cells.
// Back-pressure: a 2-entry output queue; the whole chain holds while it is full.
// Reset: aresetn synchronous active low; clears valid bits and loads default registers.
module julia_escape_time_pixel (
    input  logic                                aclk,
    input  logic                                aresetn,
    // APB-style register port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [jets_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [jets_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [jets_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready,
    // Pixel input
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [jets_pkg::S_TDATA_W-1:0]      s_tdata,   // column[9:0], row[19:10]
    // Result output
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [jets_pkg::M_TDATA_W-1:0]      m_tdata    // out_column[9:0], out_row[19:10],
                                                           // iteration_count[25:20], red[33:26],
                                                           // green[41:34], blue[49:42]
);

    jets_pkg::fix_t     origin_re_reg;
    jets_pkg::fix_t     origin_im_reg;
    jets_pkg::fix_t     step_re_reg;
    jets_pkg::fix_t     step_im_reg;
    jets_pkg::fix_t     const_re_reg;
    jets_pkg::fix_t     const_im_reg;
    jets_pkg::count_t   max_iter_reg;
    jets_pkg::count_t   limit;
    jets_pkg::reg_idx_t reg_idx;
    logic               cfg_wr;
    logic               en;
    jets_pkg::pix_t     chain [jets_pkg::MAX_ITERATIONS+1];

    // Register port
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = jets_pkg::reg_idx_t'(paddr[4:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            origin_re_reg <= jets_pkg::RST_ORIGIN_RE;
            origin_im_reg <= jets_pkg::RST_ORIGIN_IM;
            step_re_reg   <= jets_pkg::RST_STEP_RE;
            step_im_reg   <= jets_pkg::RST_STEP_IM;
            const_re_reg  <= jets_pkg::RST_CONST_RE;
            const_im_reg  <= jets_pkg::RST_CONST_IM;
            max_iter_reg  <= jets_pkg::RST_MAX_ITER;
        end else if (cfg_wr) begin
            case (reg_idx)
                jets_pkg::REG_ORIGIN_RE: origin_re_reg <= pwdata;
                jets_pkg::REG_ORIGIN_IM: origin_im_reg <= pwdata;
                jets_pkg::REG_STEP_RE:   step_re_reg   <= pwdata;
                jets_pkg::REG_STEP_IM:   step_im_reg   <= pwdata;
                jets_pkg::REG_CONST_RE:  const_re_reg  <= pwdata;
                jets_pkg::REG_CONST_IM:  const_im_reg  <= pwdata;
                jets_pkg::REG_MAX_ITER:  max_iter_reg  <= pwdata[jets_pkg::COUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Read back
    always_comb begin
        case (reg_idx)
            jets_pkg::REG_ORIGIN_RE: prdata = origin_re_reg;
            jets_pkg::REG_ORIGIN_IM: prdata = origin_im_reg;
            jets_pkg::REG_STEP_RE:   prdata = step_re_reg;
            jets_pkg::REG_STEP_IM:   prdata = step_im_reg;
            jets_pkg::REG_CONST_RE:  prdata = const_re_reg;
            jets_pkg::REG_CONST_IM:  prdata = const_im_reg;
            jets_pkg::REG_MAX_ITER:  prdata = jets_pkg::CFG_DATA_W'(max_iter_reg);
            default:                 prdata = '0;
        endcase
    end

    // Effective limit, capped at the chain length
    assign limit = (max_iter_reg > jets_pkg::MAX_COUNT) ? jets_pkg::MAX_COUNT : max_iter_reg;

    assign s_tready = en;

    jets_entry u_entry (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_vld    (s_tvalid),
        .col       (s_tdata[9:0]),
        .row       (s_tdata[19:10]),
        .origin_re (origin_re_reg),
        .origin_im (origin_im_reg),
        .step_re   (step_re_reg),
        .step_im   (step_im_reg),
        .pix_out   (chain[0])
    );

    // One cell per iteration
    for (genvar g = 0; g < jets_pkg::MAX_ITERATIONS; g++) begin : g_cell
        jets_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .const_re (const_re_reg),
            .const_im (const_im_reg),
            .limit    (limit),
            .pix_in   (chain[g]),
            .pix_out  (chain[g+1])
        );
    end

    jets_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .pix_in   (chain[jets_pkg::MAX_ITERATIONS]),
        .limit    (limit),
        .en       (en),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

FILE: design/jets_entry.sv
// Entry stages: clamp the coordinate and map it to the start point.
module jets_entry (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_vld,
    input  jets_pkg::coord_t      col,
    input  jets_pkg::coord_t      row,
    input  jets_pkg::fix_t        origin_re,
    input  jets_pkg::fix_t        origin_im,
    input  jets_pkg::fix_t        step_re,
    input  jets_pkg::fix_t        step_im,
    output jets_pkg::pix_t        pix_out
);

    logic                                   vld_a_reg;
    jets_pkg::coord_t                       col_a_reg;
    jets_pkg::coord_t                       row_a_reg;
    logic signed [jets_pkg::CMUL_W-1:0]     pcol_a_reg;
    logic signed [jets_pkg::CMUL_W-1:0]     prow_a_reg;
    jets_pkg::coord_t                       col_c;
    jets_pkg::coord_t                       row_c;
    logic signed [jets_pkg::CMUL_W-1:0]     pcol_next;
    logic signed [jets_pkg::CMUL_W-1:0]     prow_next;
    jets_pkg::pix_t                         pix_reg;
    jets_pkg::pix_t                         pix_next;

    // Clamp to the frame for the start point only
    assign col_c = (32'(col) >= 32'(jets_pkg::COLUMNS)) ?
                   jets_pkg::COORD_W'(jets_pkg::COLUMNS - 1) : col;
    assign row_c = (32'(row) >= 32'(jets_pkg::ROWS)) ?
                   jets_pkg::COORD_W'(jets_pkg::ROWS - 1) : row;

    // Scale coordinate by step
    assign pcol_next = jets_pkg::CMUL_W'($signed({1'b0, col_c}))
                     * jets_pkg::CMUL_W'(step_re);
    assign prow_next = jets_pkg::CMUL_W'($signed({1'b0, row_c}))
                     * jets_pkg::CMUL_W'(step_im);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_a_reg <= 1'b0;
        end else if (en) begin
            vld_a_reg <= in_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            col_a_reg  <= col;
            row_a_reg  <= row;
            pcol_a_reg <= pcol_next;
            prow_a_reg <= prow_next;
        end
    end

    // Add origin and saturate
    always_comb begin
        pix_next.vld   = vld_a_reg;
        pix_next.run   = 1'b1;
        pix_next.count = '0;
        pix_next.zx    = jets_pkg::sat_fix(jets_pkg::SUM_W'(pcol_a_reg)
                                           + jets_pkg::SUM_W'(origin_re));
        pix_next.zy    = jets_pkg::sat_fix(jets_pkg::SUM_W'(prow_a_reg)
                                           + jets_pkg::SUM_W'(origin_im));
        pix_next.col   = col_a_reg;
        pix_next.row   = row_a_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pix_reg.vld <= 1'b0;
        end else if (en) begin
            pix_reg <= pix_next;
        end
    end

    assign pix_out = pix_reg;

endmodule

FILE: design/jets_cell.sv
// One iteration cell: square the point, test escape, step z = z*z + c.
`include "julia_escape_time_pixel_defines.svh"

module jets_cell (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  jets_pkg::fix_t        const_re,
    input  jets_pkg::fix_t        const_im,
    input  jets_pkg::count_t      limit,
    input  jets_pkg::pix_t        pix_in,
    output jets_pkg::pix_t        pix_out
);

    jets_pkg::sq_t   sq_reg;
    jets_pkg::sq_t   sq_next;
    jets_pkg::pix_t  out_reg;
    jets_pkg::pix_t  out_next;
    jets_pkg::sum_t  xx;
    jets_pkg::sum_t  yy;
    jets_pkg::sum_t  xy;
    jets_pkg::sum_t  mag;
    jets_pkg::fix_t  nx;
    jets_pkg::fix_t  ny;
    logic            iterate;

    // First half: the three products
    always_comb begin
        sq_next.vld   = pix_in.vld;
        sq_next.run   = pix_in.run;
        sq_next.count = pix_in.count;
        sq_next.zx    = pix_in.zx;
        sq_next.zy    = pix_in.zy;
        sq_next.col   = pix_in.col;
        sq_next.row   = pix_in.row;
        sq_next.pxx   = jets_pkg::MUL_W'(pix_in.zx) * jets_pkg::MUL_W'(pix_in.zx);
        sq_next.pyy   = jets_pkg::MUL_W'(pix_in.zy) * jets_pkg::MUL_W'(pix_in.zy);
        sq_next.pxy   = jets_pkg::MUL_W'(pix_in.zx) * jets_pkg::MUL_W'(pix_in.zy);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_reg.vld <= 1'b0;
        end else if (en) begin
            sq_reg <= sq_next;
        end
    end

    // Second half: rescale, escape test, next point
    assign xx  = jets_pkg::SUM_W'(sq_reg.pxx >>> jets_pkg::FRAC_BITS);
    assign yy  = jets_pkg::SUM_W'(sq_reg.pyy >>> jets_pkg::FRAC_BITS);
    assign xy  = jets_pkg::SUM_W'(sq_reg.pxy >>> (jets_pkg::FRAC_BITS - 1));
    assign mag = xx + yy;
    assign nx  = jets_pkg::sat_fix(xx - yy + jets_pkg::SUM_W'(const_re));
    assign ny  = jets_pkg::sat_fix(xy + jets_pkg::SUM_W'(const_im));

    // Iterate only while running, inside the disk and under the limit
    assign iterate = sq_reg.run && (mag < jets_pkg::FOUR_FIX) && (sq_reg.count < limit);

    always_comb begin
        out_next.vld   = sq_reg.vld;
        out_next.run   = iterate;
        out_next.count = sq_reg.count + jets_pkg::COUNT_W'(iterate);
        out_next.zx    = iterate ? nx : sq_reg.zx;
        out_next.zy    = iterate ? ny : sq_reg.zy;
        out_next.col   = sq_reg.col;
        out_next.row   = sq_reg.row;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_reg.vld <= 1'b0;
        end else if (en) begin
            out_reg <= out_next;
        end
    end

    assign pix_out = out_reg;

    // Count never passes the hard iteration cap
    `JETS_ASSERT_IMPLY(a_count_cap, out_reg.vld, out_reg.count <= jets_pkg::MAX_COUNT, "iteration count above cap")
    // A point still running has done at least one iteration
    `JETS_ASSERT_IMPLY(a_run_count, out_reg.vld && out_reg.run, out_reg.count != '0, "running point with zero count")
    // A stopped point never resumes in this cell
    `JETS_ASSERT_NEXT(a_no_restart, en && sq_next.vld && !sq_next.run, !out_next.run, "stopped point resumed")

endmodule

FILE: design/jets_out.sv
// Palette and two-entry output queue of the Julia escape-time pixel.
`include "julia_escape_time_pixel_defines.svh"

module jets_out (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  jets_pkg::pix_t                    pix_in,
    input  jets_pkg::count_t                  limit,
    output logic                              en,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [jets_pkg::M_TDATA_W-1:0]    m_tdata
);

    localparam logic [1:0] FULL_CNT = 2'd2;

    logic [jets_pkg::M_TDATA_W-1:0]   entry_reg [2];
    logic                             wr_ptr_reg;
    logic                             rd_ptr_reg;
    logic [1:0]                       cnt_reg;
    logic [1:0]                       cnt_next;
    logic                             push;
    logic                             pop;
    logic                             black;
    logic [jets_pkg::COLOR_W-1:0]     red;
    logic [jets_pkg::COLOR_W-1:0]     green;
    logic [jets_pkg::COLOR_W-1:0]     blue;
    logic [jets_pkg::M_TDATA_W-1:0]   word;

    // Palette: black when the limit was reached
    assign black = (pix_in.count == limit);
    assign red   = black ? '0 : jets_pkg::COLOR_W'(jets_pkg::COLOR_W'(pix_in.count) * 8'd10);
    assign green = black ? '0 : jets_pkg::COLOR_W'(jets_pkg::COLOR_W'(pix_in.count) * 8'd5);
    assign blue  = black ? '0 : jets_pkg::COLOR_W'(jets_pkg::COLOR_W'(pix_in.count) * 8'd15);
    assign word  = {{jets_pkg::M_PAD_W{1'b0}}, blue, green, red,
                    pix_in.count, pix_in.row, pix_in.col};

    // Advance the pipeline while the queue has room
    assign en       = (cnt_reg != FULL_CNT);
    assign push     = en && pix_in.vld;
    assign m_tvalid = (cnt_reg != 2'd0);
    assign pop      = m_tvalid && m_tready;
    assign m_tdata  = entry_reg[rd_ptr_reg];
    assign cnt_next = cnt_reg + 2'(push) - 2'(pop);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_next;
        end
    end

    // Store the transfer word
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= word;
        end
    end

    // Occupancy stays within two entries
    `JETS_ASSERT_IMPLY(a_cnt_range, 1'b1, cnt_reg != 2'd3, "queue count out of range")
    // A full queue that is not drained stays full and takes nothing
    `JETS_ASSERT_NEXT(a_full_hold, (cnt_reg == FULL_CNT) && !m_tready, cnt_reg == FULL_CNT, "full queue changed without a transfer")
    // A waiting result stays offered and unchanged
    `JETS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "waiting result changed")

endmodule

FILE: verif/testbench.sv
// Self-checking stream testbench for the Julia escape-time pixel pipeline.
`timescale 1ns / 1ps

module testbench;

    localparam int     LONG_HOLD   = 500;
    localparam int     IDLE_LIMIT  = 3000;
    localparam int     TAIL_CYCLES = 100;
    localparam int     S_PAD_W     = jets_pkg::S_TDATA_W - 2 * jets_pkg::COORD_W;
    localparam int     COUNT_LSB   = 2 * jets_pkg::COORD_W;
    localparam int     RED_LSB     = COUNT_LSB + jets_pkg::COUNT_W;
    localparam int     GREEN_LSB   = RED_LSB + jets_pkg::COLOR_W;
    localparam int     BLUE_LSB    = GREEN_LSB + jets_pkg::COLOR_W;
    localparam longint ESCAPE_SQ   = longint'(4) << jets_pkg::FRAC_BITS;
    localparam jets_pkg::fix_t ONE_AND_HALF = jets_pkg::fix_t'(3) <<< (jets_pkg::FRAC_BITS - 1);
    localparam logic [jets_pkg::CFG_ADDR_W-1:0] UNMAPPED_ADDR = 5'd28;

    typedef struct {
        jets_pkg::coord_t             column;
        jets_pkg::coord_t             row;
        jets_pkg::count_t             iters;
        logic [jets_pkg::COLOR_W-1:0] red;
        logic [jets_pkg::COLOR_W-1:0] green;
        logic [jets_pkg::COLOR_W-1:0] blue;
        bit                           at_limit;
    } pixel_result_t;

    logic                            aclk     = 1'b0;
    logic                            aresetn  = 1'b0;
    logic                            psel     = 1'b0;
    logic                            penable  = 1'b0;
    logic                            pwrite   = 1'b0;
    logic [jets_pkg::CFG_ADDR_W-1:0] paddr    = '0;
    logic [jets_pkg::CFG_DATA_W-1:0] pwdata   = '0;
    logic [jets_pkg::CFG_DATA_W-1:0] prdata;
    logic                            pready;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [jets_pkg::S_TDATA_W-1:0]  s_tdata  = '0;   // column[9:0], row[19:10]
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [jets_pkg::M_TDATA_W-1:0]  m_tdata;  // out_column, out_row, count, red, green, blue

    // Shadow copy of the register file
    jets_pkg::fix_t   view_re    = jets_pkg::RST_ORIGIN_RE;
    jets_pkg::fix_t   view_im    = jets_pkg::RST_ORIGIN_IM;
    jets_pkg::fix_t   pitch_re   = jets_pkg::RST_STEP_RE;
    jets_pkg::fix_t   pitch_im   = jets_pkg::RST_STEP_IM;
    jets_pkg::fix_t   seed_re    = jets_pkg::RST_CONST_RE;
    jets_pkg::fix_t   seed_im    = jets_pkg::RST_CONST_IM;
    jets_pkg::count_t iter_limit = jets_pkg::RST_MAX_ITER;

    logic [2*jets_pkg::COORD_W-1:0] pixel_queue[$];
    pixel_result_t                  predicted_pixels[$];

    int unsigned pixels_queued  = 0;
    int unsigned pixels_sent    = 0;
    int unsigned results_seen   = 0;
    int unsigned limit_hits     = 0;
    int unsigned instant_escape = 0;
    int unsigned deepest_escape = 0;
    int unsigned input_stalls   = 0;
    int unsigned reg_writes     = 0;
    int unsigned settings_used  = 1;
    int unsigned idle_cycles    = 0;
    int unsigned errors         = 0;
    bit          pixel_taken    = 1'b0;
    bit          hold_request   = 1'b0;

    julia_escape_time_pixel dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Clamp a wide value to the signed 32-bit fixed-point range
    function automatic longint clamp_fix(longint v);
        if (v > longint'(jets_pkg::FIX_MAX)) begin
            return longint'(jets_pkg::FIX_MAX);
        end else if (v < longint'(jets_pkg::FIX_MIN)) begin
            return longint'(jets_pkg::FIX_MIN);
        end
        return v;
    endfunction

    // Iterate z = z*z + c for one pixel under the current register values
    function automatic pixel_result_t escape_pixel(jets_pkg::coord_t col,
                                                   jets_pkg::coord_t row);
        pixel_result_t res;
        longint        x0, y0, zx, zy, zx2, zy2, nx, ny;
        int unsigned   lim, n;
        lim = (iter_limit > jets_pkg::MAX_ITERATIONS) ? jets_pkg::MAX_ITERATIONS : iter_limit;
        // clamp coordinates outside the frame for the start point
        x0  = (col >= jets_pkg::COLUMNS) ? jets_pkg::COLUMNS - 1 : col;
        y0  = (row >= jets_pkg::ROWS) ? jets_pkg::ROWS - 1 : row;
        zx  = clamp_fix(x0 * longint'(pitch_re) + longint'(view_re));
        zy  = clamp_fix(y0 * longint'(pitch_im) + longint'(view_im));
        zx2 = (zx * zx) >>> jets_pkg::FRAC_BITS;
        zy2 = (zy * zy) >>> jets_pkg::FRAC_BITS;
        n   = 0;
        while (zx2 + zy2 < ESCAPE_SQ && n < lim) begin
            nx  = clamp_fix(zx2 - zy2 + longint'(seed_re));
            ny  = clamp_fix(((zx * zy) >>> (jets_pkg::FRAC_BITS - 1)) + longint'(seed_im));
            zx  = nx;
            zy  = ny;
            zx2 = (zx * zx) >>> jets_pkg::FRAC_BITS;
            zy2 = (zy * zy) >>> jets_pkg::FRAC_BITS;
            n++;
        end
        res.column   = col;
        res.row      = row;
        res.iters    = jets_pkg::count_t'(n);
        res.at_limit = (n == lim);
        res.red      = res.at_limit ? '0 : jets_pkg::COLOR_W'(10 * n);
        res.green    = res.at_limit ? '0 : jets_pkg::COLOR_W'(5 * n);
        res.blue     = res.at_limit ? '0 : jets_pkg::COLOR_W'(15 * n);
        return res;
    endfunction

    // Mostly back-to-back, some short gaps, a few long ones
    function automatic int unsigned pick_gap(bit steady);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (steady || roll < 65) begin
            return 0;
        end else if (roll < 96) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(12, 40);
    endfunction

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            errors++;
        end
    endtask

    // Register write: setup phase, then access phase
    task automatic apb_write(input logic [jets_pkg::CFG_ADDR_W-1:0] addr,
                             input logic [31:0] data);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (addr[jets_pkg::CFG_ADDR_W-1:2])
            jets_pkg::REG_ORIGIN_RE: view_re    = data;
            jets_pkg::REG_ORIGIN_IM: view_im    = data;
            jets_pkg::REG_STEP_RE:   pitch_re   = data;
            jets_pkg::REG_STEP_IM:   pitch_im   = data;
            jets_pkg::REG_CONST_RE:  seed_re    = data;
            jets_pkg::REG_CONST_IM:  seed_im    = data;
            jets_pkg::REG_MAX_ITER:  iter_limit = data[jets_pkg::COUNT_W-1:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic load_view(input jets_pkg::fix_t o_re, input jets_pkg::fix_t o_im,
                             input jets_pkg::fix_t s_re, input jets_pkg::fix_t s_im,
                             input jets_pkg::fix_t c_re, input jets_pkg::fix_t c_im,
                             input logic [31:0] lim_word);
        apb_write({jets_pkg::REG_ORIGIN_RE, 2'b00}, o_re);
        apb_write({jets_pkg::REG_ORIGIN_IM, 2'b00}, o_im);
        apb_write({jets_pkg::REG_STEP_RE, 2'b00}, s_re);
        apb_write({jets_pkg::REG_STEP_IM, 2'b00}, s_im);
        apb_write({jets_pkg::REG_CONST_RE, 2'b00}, c_re);
        apb_write({jets_pkg::REG_CONST_IM, 2'b00}, c_im);
        apb_write({jets_pkg::REG_MAX_ITER, 2'b00}, lim_word);
        settings_used++;
    endtask

    task automatic queue_pixel(input jets_pkg::coord_t col, input jets_pkg::coord_t row);
        pixel_queue.push_back({row, col});
        pixels_queued++;
    endtask

    // Wait until every queued pixel has been sent and its result has come back
    task automatic drain_results();
        while (pixels_sent != pixels_queued || predicted_pixels.size() != 0) begin
            @(negedge aclk);
        end
    endtask

    // Pixel sender: hold until transfer, then gap, then the next pixel
    always @(negedge aclk) begin : pixel_driver
        int unsigned tx_gap;
        bit          tx_steady;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !pixel_taken) begin
            // hold the offered pixel
        end else if (tx_gap > 0) begin
            tx_gap--;
            s_tvalid <= 1'b0;
        end else if (pixel_queue.size() != 0) begin
            s_tdata  <= {{S_PAD_W{1'b0}}, pixel_queue.pop_front()};
            s_tvalid <= 1'b1;
            tx_gap = pick_gap(tx_steady);
            if ($urandom_range(0, 63) == 0) begin
                tx_steady = !tx_steady;
            end
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    // Result receiver: random stalls plus one long hold-off
    always @(negedge aclk) begin : result_sink
        int unsigned rx_gap;
        int unsigned hold_left;
        bit          rx_steady;
        bit          hold_served;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (hold_request && !hold_served) begin
            hold_served = 1'b1;
            hold_left   = LONG_HOLD - 1;
            m_tready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            rx_gap = pick_gap(rx_steady);
            if ($urandom_range(0, 127) == 0) begin
                rx_steady = !rx_steady;
            end
        end
    end

    // Predict on input transfers, check on output transfers, watch for a hang
    always @(posedge aclk) begin : monitor
        pixel_result_t want;
        pixel_result_t got;
        bit            result_taken;
        if (aresetn) begin
            pixel_taken  = s_tvalid && s_tready;
            result_taken = m_tvalid && m_tready;
            if (pixel_taken) begin
                predicted_pixels.push_back(
                    escape_pixel(s_tdata[jets_pkg::COORD_W-1:0],
                                 s_tdata[2*jets_pkg::COORD_W-1:jets_pkg::COORD_W]));
                pixels_sent++;
            end
            if (s_tvalid && !s_tready) begin
                input_stalls++;
            end
            if (result_taken) begin
                got.column = m_tdata[jets_pkg::COORD_W-1:0];
                got.row    = m_tdata[2*jets_pkg::COORD_W-1:jets_pkg::COORD_W];
                got.iters  = m_tdata[COUNT_LSB +: jets_pkg::COUNT_W];
                got.red    = m_tdata[RED_LSB +: jets_pkg::COLOR_W];
                got.green  = m_tdata[GREEN_LSB +: jets_pkg::COLOR_W];
                got.blue   = m_tdata[BLUE_LSB +: jets_pkg::COLOR_W];
                results_seen++;
                if (predicted_pixels.size() == 0) begin
                    $error("result with no pixel outstanding: column %0d row %0d",
                           got.column, got.row);
                    errors++;
                end else begin
                    want = predicted_pixels.pop_front();
                    check_field("out_column", want.column, got.column);
                    check_field("out_row", want.row, got.row);
                    check_field("iteration_count", want.iters, got.iters);
                    check_field("red", want.red, got.red);
                    check_field("green", want.green, got.green);
                    check_field("blue", want.blue, got.blue);
                    if (want.at_limit) begin
                        limit_hits++;
                    end else if (want.iters == 0) begin
                        instant_escape++;
                    end else if (want.iters > deepest_escape) begin
                        deepest_escape = want.iters;
                    end
                end
            end
            if (pixel_taken || result_taken) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= IDLE_LIMIT) begin
                    $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
                    $display("testbench: FAIL");
                    $finish;
                end
            end
        end
    end

    initial begin : stimulus
        jets_pkg::fix_t o_re, o_im, s_re, s_im, c_re, c_im;
        logic [31:0]    lim_word;
        int unsigned    batch_len;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Corners, the pixel at z = 0 and alternating bit patterns at the reset view
        queue_pixel(10'd0, 10'd0);
        queue_pixel(10'd1023, 10'd1023);
        queue_pixel(10'd1023, 10'd0);
        queue_pixel(10'd0, 10'd1023);
        queue_pixel(10'd300, 10'd300);
        queue_pixel(10'd341, 10'd682);
        drain_results();

        // Reset view at the full limit; a write past the register map changes nothing
        load_view(jets_pkg::RST_ORIGIN_RE, jets_pkg::RST_ORIGIN_IM, jets_pkg::RST_STEP_RE,
                  jets_pkg::RST_STEP_IM, jets_pkg::RST_CONST_RE, jets_pkg::RST_CONST_IM,
                  jets_pkg::MAX_ITERATIONS);
        apb_write(UNMAPPED_ADDR, 32'hFFFF_FFFF);
        queue_pixel(10'd300, 10'd300);
        queue_pixel(10'd250, 10'd350);
        drain_results();

        // Limit zero: black without a single iteration
        apb_write({jets_pkg::REG_MAX_ITER, 2'b00}, 32'd0);
        queue_pixel(10'd300, 10'd300);
        queue_pixel(10'd0, 10'd0);
        drain_results();

        // Limit above the pipeline depth, with junk in the upper bits
        apb_write({jets_pkg::REG_MAX_ITER, 2'b00}, 32'hFFFF_FFFF);
        queue_pixel(10'd300, 10'd300);
        drain_results();

        // Single iteration limit
        apb_write({jets_pkg::REG_MAX_ITER, 2'b00}, 32'd1);
        queue_pixel(10'd300, 10'd300);
        queue_pixel(10'd0, 10'd0);
        drain_results();

        // Saturation of the start point and of the first iteration
        load_view(ONE_AND_HALF, '0, jets_pkg::FIX_MIN, jets_pkg::FIX_MAX, jets_pkg::FIX_MAX,
                  jets_pkg::FIX_MIN, jets_pkg::MAX_ITERATIONS);
        queue_pixel(10'd0, 10'd0);
        queue_pixel(10'd1023, 10'd1023);
        queue_pixel(10'd1, 10'd0);
        drain_results();

        // Start point already outside the escape circle
        load_view(jets_pkg::FIX_MIN, jets_pkg::FIX_MAX, '0, '0, '0, '0, 32'd20);
        queue_pixel(10'd512, 10'd512);
        drain_results();

        // Origin is a fixed point: runs to the limit
        load_view('0, '0, '0, '0, '0, '0, jets_pkg::MAX_ITERATIONS);
        queue_pixel(10'd7, 10'd9);
        drain_results();

        // Random views and constants, occasionally raw register values
        for (int b = 0; b < 8; b++) begin
            if ($urandom_range(0, 9) == 0) begin
                lim_word = $urandom;
            end else begin
                lim_word = ($urandom & ~32'h3F) | $urandom_range(1, jets_pkg::MAX_ITERATIONS);
            end
            if (b != 0 && $urandom_range(0, 3) == 0) begin
                load_view($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                          lim_word);
            end else begin
                o_re = $urandom_range(0, 1 << 28) - (1 << 29);
                o_im = $urandom_range(0, 1 << 28) - (1 << 29);
                s_re = $urandom_range(1 << 18, 1 << 20);
                s_im = $urandom_range(1 << 18, 1 << 20);
                c_re = $urandom_range(0, 3 << 27) - (1 << 28);
                c_im = $urandom_range(0, 1 << 29) - (1 << 28);
                load_view(o_re, o_im, s_re, s_im, c_re, c_im, lim_word);
            end
            batch_len = 110;
            if (b == 0) begin
                // long batch while the receiver holds off, to back up the chain
                batch_len    = 256;
                hold_request = 1'b1;
            end
            for (int i = 0; i < batch_len; i++) begin
                queue_pixel($urandom_range(0, 1023), $urandom_range(0, 1023));
            end
            drain_results();
        end

        repeat (TAIL_CYCLES) @(negedge aclk);
        if (predicted_pixels.size() != 0) begin
            $error("%0d results never arrived", predicted_pixels.size());
            errors++;
        end
        $display("summary: %0d pixels, %0d results under %0d register settings (%0d writes)",
                 pixels_sent, results_seen, settings_used, reg_writes);
        $display("summary: %0d at limit, %0d escaped at once, deepest escape %0d, %0d stalls",
                 limit_hits, instant_escape, deepest_escape, input_stalls);
        if (errors == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+design
design/jets_pkg.sv
design/jets_entry.sv
design/jets_cell.sv
design/jets_out.sv
design/julia_escape_time_pixel.sv
verif/testbench.sv
